// ===== sv/ipdp_pkg.sv =====
// ----------------------------------------------------------------------------
// ipdp_pkg
// Shared types and constants of the indexed pixel display packer.
// ----------------------------------------------------------------------------
package ipdp_pkg;

	localparam int PALETTE_ENTRIES = 256;
	localparam int PAL_AW          = $clog2(PALETTE_ENTRIES);
	localparam int PAL_W           = 48;
	localparam int MAX_LINE_PIXELS = 4096;
	localparam int BURST_MAX       = 5;
	localparam int BURST_CW        = 3;

	// input op codes
	localparam logic OP_PIXEL   = 1'b0;
	localparam logic OP_PALETTE = 1'b1;

	// register indexes
	localparam logic [1:0] REG_SCREEN_DEPTH = 2'd0;
	localparam logic [1:0] REG_LSB_FIRST    = 2'd1;
	localparam logic [1:0] REG_LINE_WIDTH   = 2'd2;
	localparam logic [1:0] REG_LINE_COUNT   = 2'd3;

	// supported depths
	localparam logic [5:0] DEPTH_1  = 6'd1;
	localparam logic [5:0] DEPTH_2  = 6'd2;
	localparam logic [5:0] DEPTH_4  = 6'd4;
	localparam logic [5:0] DEPTH_6  = 6'd6;
	localparam logic [5:0] DEPTH_8  = 6'd8;
	localparam logic [5:0] DEPTH_16 = 6'd16;
	localparam logic [5:0] DEPTH_24 = 6'd24;

	localparam logic [15:0] RGB_R_MASK = 16'h7c00;
	localparam logic [15:0] RGB_G_MASK = 16'h03e0;
	localparam logic [15:0] RGB_B_MASK = 16'h001f;
	localparam logic [7:0]  BYTE_MASK  = 8'hff;

	localparam logic [12:0] RST_LINE_WIDTH = 13'd640;
	localparam logic [12:0] RST_LINE_COUNT = 13'd480;
	localparam logic [12:0] MAX_WIDTH      = 13'(MAX_LINE_PIXELS);

	typedef struct packed {
		logic [5:0]  depth;
		logic        lsb_first;
		logic [12:0] line_width;
		logic [12:0] line_count;
	} cfg_t;

	typedef struct packed {
		logic [7:0]  partial;
		logic [2:0]  bitpos;
		logic [12:0] col;
		logic [12:0] row;
	} pack_state_t;

	typedef struct packed {
		logic                          op;
		logic [7:0]                    pix;
	} item_t;

	typedef struct packed {
		logic [BURST_MAX-1:0][7:0] bytes;
		logic [BURST_CW-1:0]       count;
		logic                      line_end;
		logic                      frame_end;
		logic                      err;
	} burst_t;

endpackage

// ===== sv/ipdp_ram.sv =====
// ----------------------------------------------------------------------------
// ipdp_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module ipdp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== sv/ipdp_conv.sv =====
// ----------------------------------------------------------------------------
// ipdp_conv
// Converts one registered item into a burst of display bytes and computes
// the packing and line/frame counter state that follows it.
// ----------------------------------------------------------------------------
module ipdp_conv (
	input  ipdp_pkg::item_t              item,
	input  logic [ipdp_pkg::PAL_W-1:0]   pal_entry,
	input  ipdp_pkg::cfg_t               cfg,
	input  ipdp_pkg::pack_state_t        st,
	output ipdp_pkg::burst_t             burst,
	output ipdp_pkg::pack_state_t        st_next
);
	import ipdp_pkg::*;

	logic [12:0] width_c;
	logic [12:0] count_c;
	logic [12:0] col_inc;
	logic [13:0] row_inc;
	logic        line_done;
	logic        frame_done;
	logic [3:0]  d4;
	logic [1:0]  dlog;
	logic [7:0]  pix_mask;
	logic [2:0]  shift;
	logic [7:0]  byte0;
	logic [3:0]  bit_sum;
	logic [3:0]  pad;
	logic [5:0]  line_bits;
	logic [5:0]  total_bits;
	logic [5:0]  total_rnd;
	logic [15:0] rgb555;
	logic [15:0] r16, g16, b16;

	always_comb begin
		width_c = cfg.line_width;
		if (width_c == 13'd0) begin
			width_c = 13'd1;
		end else if (width_c > MAX_WIDTH) begin
			width_c = MAX_WIDTH;
		end
		count_c = (cfg.line_count == 13'd0) ? 13'd1 : cfg.line_count;

		col_inc    = st.col + 13'd1;
		row_inc    = {1'b0, st.row} + 14'd1;
		line_done  = col_inc >= width_c;
		frame_done = line_done && (row_inc >= {1'b0, count_c});

		// packed depths: only the first byte carries pixel bits, the rest is padding
		d4 = cfg.depth[3:0];
		case (cfg.depth[2:0])
			3'd2:    dlog = 2'd1;
			3'd4:    dlog = 2'd2;
			default: dlog = 2'd0;
		endcase
		pix_mask   = item.pix & ((8'd1 << d4) - 8'd1);
		shift      = cfg.lsb_first ? st.bitpos : 3'(4'd8 - d4 - {1'b0, st.bitpos});
		byte0      = st.partial | 8'(pix_mask << shift);
		bit_sum    = {1'b0, st.bitpos} + d4;
		pad        = 4'd8 - {1'b0, width_c[2:0]};
		line_bits  = ({2'b0, pad} + 6'd1) << dlog;
		total_bits = {3'b0, st.bitpos} + line_bits;
		total_rnd  = total_bits + 6'd7;

		r16    = pal_entry[47:32];
		g16    = pal_entry[31:16];
		b16    = pal_entry[15:0];
		rgb555 = ((r16 >> 1) & RGB_R_MASK) | ((g16 >> 6) & RGB_G_MASK) |
			((b16 >> 11) & RGB_B_MASK);

		burst           = '0;
		burst.line_end  = line_done;
		burst.frame_end = frame_done;
		st_next         = st;

		if (item.op == OP_PIXEL) begin
			st_next.col = line_done ? 13'd0 : col_inc;
			if (line_done) begin
				st_next.row = frame_done ? 13'd0 : row_inc[12:0];
			end

			unique case (cfg.depth) inside
				DEPTH_1, DEPTH_2, DEPTH_4: begin
					burst.bytes[0] = byte0;
					if (line_done) begin
						burst.count     = BURST_CW'(total_rnd >> 3);
						st_next.partial = '0;
						st_next.bitpos  = '0;
					end else if (bit_sum >= 4'd8) begin
						burst.count     = BURST_CW'(1);
						st_next.partial = '0;
						st_next.bitpos  = '0;
					end else begin
						burst.count     = '0;
						st_next.partial = byte0;
						st_next.bitpos  = bit_sum[2:0];
					end
				end
				DEPTH_6, DEPTH_8: begin
					burst.bytes[0] = item.pix;
					burst.count    = BURST_CW'(1);
				end
				DEPTH_16: begin
					burst.count = BURST_CW'(2);
					if (cfg.lsb_first) begin
						burst.bytes[0] = rgb555[7:0] & BYTE_MASK;
						burst.bytes[1] = rgb555[15:8];
					end else begin
						burst.bytes[0] = rgb555[15:8];
						burst.bytes[1] = rgb555[7:0] & BYTE_MASK;
					end
				end
				DEPTH_24: begin
					burst.count = BURST_CW'(4);
					if (cfg.lsb_first) begin
						burst.bytes[0] = r16[15:8];
						burst.bytes[1] = g16[15:8];
						burst.bytes[2] = b16[15:8];
						burst.bytes[3] = 8'd0;
					end else begin
						burst.bytes[0] = 8'd0;
						burst.bytes[1] = b16[15:8];
						burst.bytes[2] = g16[15:8];
						burst.bytes[3] = r16[15:8];
					end
				end
				default: begin
					burst.count = BURST_CW'(1);
					burst.err   = 1'b1;
				end
			endcase
		end
	end

endmodule

// ===== sv/indexed_pixel_display_packer_core.sv =====
// ----------------------------------------------------------------------------
// indexed_pixel_display_packer_core
// Turns a stream of color indices into display memory bytes for the
// configured screen depth, with a palette for the direct color depths.
// ----------------------------------------------------------------------------
//  channel  | handshake           | payload
//  ---------+---------------------+-------------------------------------------
//  input    | in_valid / in_stall | op, pixel_index, entry_index, rgb levels
//  output   | out_valid/out_stall | out_byte, run_last, line_end, frame_end,
//           |                     | depth_error
//  config   | cfg_we              | cfg_index, cfg_data
//
//  an item is registered with its palette read, converted in the next cycle
//  into a burst of up to five bytes, and the bytes leave one per cycle while
//  out_stall is low; a burst holds one byte at depths 6/8, for a full packed
//  byte and at unsupported depths, two at depth 16, four at depth 24 and up
//  to five at a packed line end; palette writes and partial packs give none
//  reset clears control state, not the palette or the data registers
//  output stall holds the burst, the next item waits in the input register
// ----------------------------------------------------------------------------
module indexed_pixel_display_packer_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        op,
	input  logic [7:0]  pixel_index,
	input  logic [7:0]  entry_index,
	input  logic [15:0] red_level,
	input  logic [15:0] green_level,
	input  logic [15:0] blue_level,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  out_byte,
	output logic        run_last,
	output logic        line_end,
	output logic        frame_end,
	output logic        depth_error,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [12:0] cfg_data
);
	import ipdp_pkg::*;

	cfg_t                cfg_q;
	pack_state_t         st_q;
	pack_state_t         st_next;
	item_t               item_s1;
	logic                valid_s1;
	logic [PAL_W-1:0]    pal_rdata;
	burst_t              burst;
	burst_t              burst_s2;
	logic                valid_s2;
	logic [BURST_CW-1:0] idx_q;

	logic in_acc;
	logic adv_s1;
	logic out_acc;
	logic last_byte;
	logic free_s2;

	assign last_byte = idx_q == (burst_s2.count - BURST_CW'(1));
	assign out_acc   = valid_s2 && !out_stall;
	assign free_s2   = !valid_s2 || (out_acc && last_byte);
	assign adv_s1    = valid_s1 && ((burst.count == '0) || free_s2);
	assign in_stall  = valid_s1 && !adv_s1;
	assign in_acc    = in_valid && !in_stall;

	ipdp_ram #(
		.WIDTH(PAL_W),
		.DEPTH(PALETTE_ENTRIES)
	) u_palette (
		.clk  (clk),
		.we   (in_acc && (op == OP_PALETTE)),
		.waddr(entry_index[PAL_AW-1:0]),
		.wdata({red_level, green_level, blue_level}),
		.re   (in_acc),
		.raddr(pixel_index[PAL_AW-1:0]),
		.rdata(pal_rdata)
	);

	ipdp_conv u_conv (
		.item     (item_s1),
		.pal_entry(pal_rdata),
		.cfg      (cfg_q),
		.st       (st_q),
		.burst    (burst),
		.st_next  (st_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.depth      <= DEPTH_8;
			cfg_q.lsb_first  <= 1'b0;
			cfg_q.line_width <= RST_LINE_WIDTH;
			cfg_q.line_count <= RST_LINE_COUNT;
			st_q             <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SCREEN_DEPTH: begin
					cfg_q.depth  <= cfg_data[5:0];
					st_q.partial <= '0;
					st_q.bitpos  <= '0;
				end
				REG_LSB_FIRST: begin
					cfg_q.lsb_first <= cfg_data[0];
					st_q.partial    <= '0;
					st_q.bitpos     <= '0;
				end
				REG_LINE_WIDTH: cfg_q.line_width <= cfg_data;
				REG_LINE_COUNT: cfg_q.line_count <= cfg_data;
				default: ;
			endcase
		end else if (adv_s1) begin
			st_q <= st_next;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_acc) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			item_s1.op  <= op;
			item_s1.pix <= pixel_index;
		end
	end

	// result register and byte serializer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			idx_q    <= '0;
		end else if (adv_s1 && (burst.count != '0)) begin
			valid_s2 <= 1'b1;
			idx_q    <= '0;
		end else if (out_acc) begin
			if (last_byte) begin
				valid_s2 <= 1'b0;
			end
			idx_q <= idx_q + BURST_CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && (burst.count != '0)) begin
			burst_s2 <= burst;
		end
	end

	assign out_valid   = valid_s2;
	assign out_byte    = burst_s2.bytes[idx_q];
	assign run_last    = last_byte;
	assign line_end    = last_byte && burst_s2.line_end;
	assign frame_end   = last_byte && burst_s2.frame_end;
	assign depth_error = burst_s2.err;

	a_burst_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> (burst_s2.count != '0))
		else $error("empty burst in result register");

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> (idx_q < burst_s2.count))
		else $error("byte index beyond burst");

	a_frame_line: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && frame_end) |-> line_end)
		else $error("frame end without line end");

	a_err_byte: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && depth_error) |-> (run_last && (out_byte == 8'd0)))
		else $error("depth error item not a single zero byte");

endmodule
